FILE: rtl/terminal_line_editor_top_defines.svh
// Assertion macros shared by the terminal line editor RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef TERMINAL_LINE_EDITOR_TOP_DEFINES_SVH
`define TERMINAL_LINE_EDITOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define TLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tle_pkg.sv
// Shared constants and types for the terminal line editor.
// No dependencies; imported by terminal_line_editor_top and the testbench.
package tle_pkg;

  localparam int LINE_LENGTH = 32;
  localparam int ADDR_W      = $clog2(LINE_LENGTH);
  localparam int CUR_W       = 6;
  localparam int BYTE_W      = 8;

  localparam logic [BYTE_W-1:0] BYTE_BS    = 8'h7f;
  localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h1b;
  localparam logic [BYTE_W-1:0] BYTE_BRK   = 8'h5b;
  localparam logic [BYTE_W-1:0] BYTE_LEFT  = 8'h44;
  localparam logic [BYTE_W-1:0] BYTE_RIGHT = 8'h43;
  localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0a;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;
  localparam logic [1:0] KIND_OVF  = 2'd3;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_SEEN,
    ESC_BRACKET
  } esc_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RIGHT_CHK,
    S_ARROW_ESC,
    S_ARROW_BRK,
    S_ECHO,
    S_OVF,
    S_CR_LF,
    S_CR_CR,
    S_LINE_RD,
    S_LINE_EMIT,
    S_END
  } state_t;

endpackage

FILE: rtl/tle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/terminal_line_editor_top.sv
// Terminal line editor: takes one received byte per input word and returns echo, line,
// line-end and overflow words, the last word of each input flagged by last. The line lives
// in a 32-entry RAM with one read port. After reset, a line end or an overflow, a clearing
// pass writes zero to every RAM entry, one per cycle, during which no input is taken.
// Depends on tle_pkg, tle_ram and terminal_line_editor_top_defines.svh.
`include "terminal_line_editor_top_defines.svh"

module terminal_line_editor_top
  import tle_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        kind,
  output logic [BYTE_W-1:0] data_byte,
  output logic [CUR_W-1:0]  final_cursor,
  output logic              last
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LINE_LENGTH - 1);
  localparam logic [CUR_W-1:0]  CUR_LIMIT = CUR_W'(LINE_LENGTH);

  state_t             state, state_next;
  esc_t               phase, phase_next;
  logic [CUR_W-1:0]   cursor, cursor_next;
  logic [ADDR_W-1:0]  idx, idx_next;
  logic [BYTE_W-1:0]  hold, hold_next;
  logic               ovf_pend, ovf_next;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [BYTE_W-1:0]  wr_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic [BYTE_W-1:0]  rd_data;

  logic               out_free;
  logic               load;
  logic [1:0]         ld_kind;
  logic [BYTE_W-1:0]  ld_data;
  logic [CUR_W-1:0]   ld_cur;
  logic               ld_last;

  logic [CUR_W-1:0]   cur_inc, cur_dec;

  tle_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_LENGTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid || out_ready;
  assign cur_inc  = cursor + CUR_W'(1);
  assign cur_dec  = cursor - CUR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      phase    <= ESC_IDLE;
      cursor   <= '0;
      idx      <= '0;
      ovf_pend <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      cursor   <= cursor_next;
      idx      <= idx_next;
      ovf_pend <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    hold <= hold_next;
  end

  always_comb begin
    state_next  = state;
    phase_next  = phase;
    cursor_next = cursor;
    idx_next    = idx;
    hold_next   = hold;
    ovf_next    = ovf_pend;
    in_ready    = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = cursor[ADDR_W-1:0];
    wr_data     = '0;
    rd_addr     = cursor[ADDR_W-1:0];
    load        = 1'b0;
    ld_kind     = KIND_ECHO;
    ld_data     = '0;
    ld_cur      = '0;
    ld_last     = 1'b0;

    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = idx;
        if (idx == LAST_ADDR) begin
          idx_next   = '0;
          state_next = S_IDLE;
        end else begin
          idx_next = idx + ADDR_W'(1);
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (phase)
            ESC_SEEN: begin
              phase_next = (rx_byte == BYTE_BRK) ? ESC_BRACKET : ESC_IDLE;
            end
            ESC_BRACKET: begin
              phase_next = ESC_IDLE;
              if (rx_byte == BYTE_LEFT) begin
                hold_next  = BYTE_LEFT;
                ovf_next   = 1'b0;
                state_next = S_ARROW_ESC;
                if (cursor != '0) begin
                  cursor_next = cur_dec;
                end
              end else if (rx_byte == BYTE_RIGHT) begin
                // cell under the cursor is read this cycle, checked next
                state_next = S_RIGHT_CHK;
              end
            end
            default: begin
              phase_next = ESC_IDLE;
              if (rx_byte == BYTE_CR) begin
                state_next = S_CR_LF;
              end else if (rx_byte == BYTE_BS) begin
                if (cursor != '0) begin
                  cursor_next = cur_dec;
                  wr_en       = 1'b1;
                  wr_addr     = cur_dec[ADDR_W-1:0];
                  hold_next   = rx_byte;
                  ovf_next    = 1'b0;
                  state_next  = S_ECHO;
                end
              end else if (rx_byte == BYTE_ESC) begin
                phase_next = ESC_SEEN;
              end else begin
                if (cursor < CUR_LIMIT) begin
                  wr_en   = 1'b1;
                  wr_data = rx_byte;
                end
                hold_next   = rx_byte;
                cursor_next = cur_inc;
                ovf_next    = (cur_inc >= CUR_LIMIT);
                state_next  = S_ECHO;
              end
            end
          endcase
        end
      end

      S_RIGHT_CHK: begin
        if ((cursor < CUR_LIMIT) && (rd_data != '0)) begin
          hold_next   = BYTE_RIGHT;
          cursor_next = cur_inc;
          ovf_next    = (cur_inc >= CUR_LIMIT);
          state_next  = S_ARROW_ESC;
        end else begin
          state_next = S_IDLE;
        end
      end

      S_ARROW_ESC: begin
        if (out_free) begin
          load       = 1'b1;
          ld_data    = BYTE_ESC;
          state_next = S_ARROW_BRK;
        end
      end

      S_ARROW_BRK: begin
        if (out_free) begin
          load       = 1'b1;
          ld_data    = BYTE_BRK;
          state_next = S_ECHO;
        end
      end

      S_ECHO: begin
        if (out_free) begin
          load       = 1'b1;
          ld_data    = hold;
          ld_last    = !ovf_pend;
          state_next = ovf_pend ? S_OVF : S_IDLE;
        end
      end

      S_OVF: begin
        if (out_free) begin
          load        = 1'b1;
          ld_kind     = KIND_OVF;
          ld_last     = 1'b1;
          cursor_next = '0;
          idx_next    = '0;
          state_next  = S_CLEAR;
        end
      end

      S_CR_LF: begin
        if (out_free) begin
          load       = 1'b1;
          ld_data    = BYTE_LF;
          state_next = S_CR_CR;
        end
      end

      S_CR_CR: begin
        if (out_free) begin
          load       = 1'b1;
          ld_data    = BYTE_CR;
          idx_next   = '0;
          state_next = S_LINE_RD;
        end
      end

      S_LINE_RD: begin
        rd_addr    = idx;
        state_next = S_LINE_EMIT;
      end

      S_LINE_EMIT: begin
        // hold the address so the read data stays put through an output stall
        rd_addr = idx;
        if (rd_data == '0) begin
          state_next = S_END;
        end else if (out_free) begin
          load    = 1'b1;
          ld_kind = KIND_LINE;
          ld_data = rd_data;
          if (idx == LAST_ADDR) begin
            idx_next   = '0;
            state_next = S_END;
          end else begin
            idx_next   = idx + ADDR_W'(1);
            state_next = S_LINE_RD;
          end
        end
      end

      S_END: begin
        if (out_free) begin
          load        = 1'b1;
          ld_kind     = KIND_END;
          ld_cur      = cursor;
          ld_last     = 1'b1;
          cursor_next = '0;
          idx_next    = '0;
          state_next  = S_CLEAR;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register: a new word loads only when the old one has left
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind         <= ld_kind;
      data_byte    <= ld_data;
      final_cursor <= ld_cur;
      last         <= ld_last;
    end
  end

  `TLE_ASSERT_NOW(a_cursor_range, 1'b1, cursor <= CUR_LIMIT, "cursor beyond line length")
  `TLE_ASSERT_NOW(a_line_nonzero, out_valid && (kind == KIND_LINE), data_byte != '0,
                  "zero byte emitted as line content")
  `TLE_ASSERT_NOW(a_end_is_last, out_valid && ((kind == KIND_END) || (kind == KIND_OVF)),
                  last, "line end or overflow word not flagged last")
  `TLE_ASSERT_NOW(a_scan_no_write, (state == S_LINE_RD) || (state == S_LINE_EMIT),
                  !wr_en, "line store written during line scan")
  `TLE_ASSERT_NEXT(a_clear_cursor, load && ((ld_kind == KIND_END) || (ld_kind == KIND_OVF)),
                   (cursor == '0) && (state == S_CLEAR), "line not cleared after line end")

endmodule

FILE: sim/tb.sv
// Testbench for terminal_line_editor_top: feeds received bytes, predicts every
// echo, line, line-end and overflow word, and checks each output word in order.
// Depends on tle_pkg and the terminal_line_editor_top RTL.
`timescale 1ns / 1ps

module tb;
  import tle_pkg::*;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] data;
    logic [CUR_W-1:0]  fcur;
    logic              last;
  } edit_word_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        kind;
  logic [BYTE_W-1:0] data_byte;
  logic [CUR_W-1:0]  final_cursor;
  logic              last;

  // Shadow copy of the editor state
  logic [BYTE_W-1:0] line_mem [LINE_LENGTH];
  int unsigned       cur_pos;
  esc_t              esc_state;
  edit_word_t        pending_words[$];

  int bytes_fed;
  int words_seen;
  int ends_seen;
  int ovf_seen;
  int mismatches;
  int stray_words;
  bit steady;

  terminal_line_editor_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .data_byte   (data_byte),
    .final_cursor(final_cursor),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d words still pending", pending_words.size());
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic void push_word(logic [1:0] k, logic [BYTE_W-1:0] d,
                                    logic [CUR_W-1:0] c);
    edit_word_t w;
    w.kind = k;
    w.data = d;
    w.fcur = c;
    w.last = 1'b0;
    pending_words.push_back(w);
  endfunction

  function automatic void wipe_line();
    for (int i = 0; i < LINE_LENGTH; i++) line_mem[i] = '0;
    cur_pos = 0;
  endfunction

  function automatic void flag_overflow();
    if (cur_pos >= LINE_LENGTH) begin
      push_word(KIND_OVF, '0, '0);
      wipe_line();
    end
  endfunction

  function automatic void push_arrow(logic [BYTE_W-1:0] final_b);
    push_word(KIND_ECHO, BYTE_ESC, '0);
    push_word(KIND_ECHO, BYTE_BRK, '0);
    push_word(KIND_ECHO, final_b, '0);
  endfunction

  function automatic void edit_line(logic [BYTE_W-1:0] b);
    int         n0;
    edit_word_t w;
    n0 = pending_words.size();
    if (esc_state == ESC_SEEN) begin
      esc_state = (b == BYTE_BRK) ? ESC_BRACKET : ESC_IDLE;
    end else if (esc_state == ESC_BRACKET) begin
      esc_state = ESC_IDLE;
      if (b == BYTE_LEFT) begin
        push_arrow(BYTE_LEFT);
        if (cur_pos > 0) cur_pos--;
      end else if (b == BYTE_RIGHT) begin
        if (cur_pos < LINE_LENGTH && line_mem[cur_pos] != 0) begin
          push_arrow(BYTE_RIGHT);
          cur_pos++;
          flag_overflow();
        end
      end
    end else begin
      esc_state = ESC_IDLE;
      if (b == BYTE_CR) begin
        push_word(KIND_ECHO, BYTE_LF, '0);
        push_word(KIND_ECHO, BYTE_CR, '0);
        for (int i = 0; i < LINE_LENGTH && line_mem[i] != 0; i++)
          push_word(KIND_LINE, line_mem[i], '0);
        push_word(KIND_END, '0, cur_pos[CUR_W-1:0]);
        wipe_line();
      end else if (b == BYTE_BS) begin
        if (cur_pos > 0) begin
          push_word(KIND_ECHO, b, '0);
          cur_pos--;
          line_mem[cur_pos] = '0;
        end
      end else if (b == BYTE_ESC) begin
        esc_state = ESC_SEEN;
      end else begin
        push_word(KIND_ECHO, b, '0);
        if (cur_pos < LINE_LENGTH) line_mem[cur_pos] = b;
        cur_pos++;
        flag_overflow();
      end
    end
    // mark the final word of this byte
    if (pending_words.size() > n0) begin
      w = pending_words.pop_back();
      w.last = 1'b1;
      pending_words.push_back(w);
    end
  endfunction

  // ---------------- monitor and checker ----------------

  always @(posedge clk) begin
    edit_word_t got;
    edit_word_t want;
    if (!rst) begin
      if (in_valid && in_ready) edit_line(rx_byte);
      if (out_valid && out_ready) begin
        got.kind = kind;
        got.data = data_byte;
        got.fcur = final_cursor;
        got.last = last;
        words_seen++;
        if (kind == KIND_END) ends_seen++;
        if (kind == KIND_OVF) ovf_seen++;
        if (pending_words.size() == 0) begin
          stray_words++;
          if (mismatches + stray_words <= 10)
            $display("%0t: unexpected word kind=%0d data=%02h cur=%0d last=%0b",
                     $realtime, got.kind, got.data, got.fcur, got.last);
        end else begin
          want = pending_words.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches + stray_words <= 10)
              $display({"%0t: mismatch exp kind=%0d data=%02h cur=%0d last=%0b",
                        " got kind=%0d data=%02h cur=%0d last=%0b"}, $realtime,
                       want.kind, want.data, want.fcur, want.last,
                       got.kind, got.data, got.fcur, got.last);
          end
        end
      end
    end
  end

  // Output side stalls unless inside the steady stretch
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= steady || ($urandom_range(0, 99) >= 14);
  end

  // ---------------- stimulus ----------------

  task automatic send_byte(logic [BYTE_W-1:0] b);
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_fed++;
  endtask

  task automatic send_arrow(logic [BYTE_W-1:0] final_b);
    send_byte(BYTE_ESC);
    send_byte(BYTE_BRK);
    send_byte(final_b);
  endtask

  // Stored zero byte cuts the emitted line short; extremes of the byte range
  task automatic test_plain_bytes();
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(BYTE_CR);
  endtask

  task automatic test_backspace();
    send_byte(BYTE_BS);   // at column zero: no word
    send_byte(8'h78);
    send_byte(BYTE_BS);
    send_byte(BYTE_CR);
  endtask

  task automatic test_arrows();
    send_arrow(BYTE_LEFT);   // left at column zero still echoes
    send_byte(8'h70);
    send_arrow(BYTE_LEFT);
    send_arrow(BYTE_RIGHT);  // over a stored byte
    send_arrow(BYTE_RIGHT);  // over an empty cell: dropped
  endtask

  task automatic test_escape_drop();
    send_byte(BYTE_ESC);
    send_byte(8'h78);        // not a bracket: dropped
    send_byte(BYTE_ESC);
    send_byte(BYTE_BRK);
    send_byte(8'h5a);        // unknown final byte: dropped
    send_byte(BYTE_CR);
  endtask

  task automatic send_edit(int plain_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < plain_pct) begin
      send_byte(8'($urandom_range(8'h20, 8'h7e)));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 25) send_byte(BYTE_BS);
      else if (r < 50) send_arrow(BYTE_LEFT);
      else if (r < 70) send_arrow(BYTE_RIGHT);
      else if (r < 80) begin
        // broken sequence
        send_byte(BYTE_ESC);
        send_byte(8'($urandom_range(0, 255)));
      end else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_lines(int target);
    int len;
    int line_no;
    bit long_line;
    line_no = 0;
    while (bytes_fed < target) begin
      steady    = (line_no >= 12 && line_no < 20);
      long_line = ($urandom_range(0, 99) < 18);
      len       = long_line ? $urandom_range(30, 40) : $urandom_range(0, 12);
      for (int i = 0; i < len; i++) send_edit(long_line ? 90 : 60);
      if ($urandom_range(0, 99) < 90) send_byte(BYTE_CR);
      line_no++;
    end
    steady = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    rx_byte   = '0;
    steady    = 1'b0;
    esc_state = ESC_IDLE;
    wipe_line();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_plain_bytes();
    test_backspace();
    test_arrows();
    test_escape_drop();
    test_random_lines(410);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Fed %0d bytes and checked %0d words: %0d line ends, %0d overflows",
             bytes_fed, words_seen, ends_seen, ovf_seen);
    $display("Mismatches %0d, unexpected words %0d, words left over %0d",
             mismatches, stray_words, pending_words.size());
    if (mismatches == 0 && stray_words == 0 && pending_words.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
